[design/pcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the phase-one coordinate codec
// Holds the binomial table, the cell chain's stage record and the field
// widths that the cell and the top level both use.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int SLOTS        = 12;   // edge slots, one cell each
   localparam int TWIST_CELLS  = 7;    // corners carried in the coordinate
   localparam int FLIP_CELLS   = 11;   // edges carried in the coordinate
   localparam int TWIST_MAX    = 2186;
   localparam int SLICE_MAX    = 494;
   localparam int SLICE_EDGES  = 4;

   // floor(c / 3) == (c * TWIST_RECIP) >> TWIST_SHIFT for every 12-bit c
   localparam logic [11:0] TWIST_RECIP = 12'd2731;
   localparam int          TWIST_SHIFT = 13;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // C(n, k) for n = 0..11, k = 0..4
   localparam logic [8:0] BINOM [12][5] = '{
      '{9'd1, 9'd0,  9'd0,  9'd0,   9'd0},
      '{9'd1, 9'd1,  9'd0,  9'd0,   9'd0},
      '{9'd1, 9'd2,  9'd1,  9'd0,   9'd0},
      '{9'd1, 9'd3,  9'd3,  9'd1,   9'd0},
      '{9'd1, 9'd4,  9'd6,  9'd4,   9'd1},
      '{9'd1, 9'd5,  9'd10, 9'd10,  9'd5},
      '{9'd1, 9'd6,  9'd15, 9'd20,  9'd15},
      '{9'd1, 9'd7,  9'd21, 9'd35,  9'd35},
      '{9'd1, 9'd8,  9'd28, 9'd56,  9'd70},
      '{9'd1, 9'd9,  9'd36, 9'd84,  9'd126},
      '{9'd1, 9'd10, 9'd45, 9'd120, 9'd210},
      '{9'd1, 9'd11, 9'd55, 9'd165, 9'd330}
   };

   // one item as it travels down the cell chain
   typedef struct packed {
      logic        valid;
      logic        cmd;
      logic        err;
      logic [13:0] tdig;       // input twists, current corner in the low bits
      logic [10:0] fbits;      // input flips, current edge in bit 0
      logic [47:0] pieces;     // input pieces, current slot in the low nibble
      logic [11:0] t_acc;      // twist sum (encode) or quotient left (decode)
      logic [10:0] f_acc;      // flip sum (encode) or coordinate shifter (decode)
      logic [8:0]  s_acc;      // slice sum (encode) or rank left (decode)
      logic [2:0]  k;          // slice edges still to place
      logic [1:0]  par_t;      // twist sum mod 3
      logic        par_f;      // flip parity
      logic [13:0] tdig_o;     // decoded twists of corners 0..6
      logic [10:0] fbits_o;    // decoded flips of edges 0..10
      logic [47:0] pieces_o;   // rewritten pieces
   } stage_type;

endpackage

[design/pcc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_cell: one slot of the codec chain
// Handles one slot per item, plus one corner (cells 0..6) and one edge flip
// (cells 0..10), then registers the item for the next cell.
// ----------------------------------------------------------------------------
module pcc_cell
   import pcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [3:0]      cell_index,
   input  stage_type       stage_in,
   output stage_type       stage_out
);

   stage_type   slot_ff;
   stage_type   slot_in;
   logic [3:0]  row;
   logic [3:0]  p;
   logic [3:0]  p_new;
   logic [8:0]  coef;
   logic [1:0]  d;
   logic [23:0] prod;
   logic [10:0] q;
   logic [11:0] rem3;
   logic [2:0]  psum;
   logic        fb;
   logic        twist_act;
   logic        flip_act;

   assign row       = 4'(SLOTS - 1) - cell_index;
   assign twist_act = (cell_index < 4'(TWIST_CELLS));
   assign flip_act  = (cell_index < 4'(FLIP_CELLS));
   assign coef      = BINOM[row][stage_in.k];

   // divide by three through the reciprocal
   assign prod = 24'(stage_in.t_acc) * 24'(TWIST_RECIP);
   assign q    = prod[23:TWIST_SHIFT];
   assign rem3 = stage_in.t_acc - {q, 1'b0} - 12'(q);

   always_comb begin
      slot_in = stage_in;
      p       = stage_in.pieces[3:0];
      p_new   = p;
      d       = 2'd0;
      fb      = 1'b0;
      psum    = 3'd0;
      slot_in.pieces = {4'd0, stage_in.pieces[47:4]};

      if (stage_in.cmd == CMD_ENCODE) begin
         if (twist_act) begin
            d = stage_in.tdig[1:0];
            if (d == 2'd3) begin
               slot_in.err = 1'b1;
            end
            slot_in.t_acc = 12'({stage_in.t_acc, 1'b0}) + stage_in.t_acc + 12'(d);
            slot_in.tdig  = {2'd0, stage_in.tdig[13:2]};
         end
         if (flip_act) begin
            slot_in.f_acc = {stage_in.f_acc[9:0], stage_in.fbits[0]};
            slot_in.fbits = {1'b0, stage_in.fbits[10:1]};
         end
         if (p > 4'd11) begin
            slot_in.err = 1'b1;
         end
         if (p >= 4'd8 && p <= 4'd11 && stage_in.k != 3'd0) begin
            slot_in.s_acc = stage_in.s_acc + coef;
            slot_in.k     = stage_in.k - 3'd1;
         end
      end else begin
         if (twist_act) begin
            d    = rem3[1:0];
            psum = 3'(stage_in.par_t) + 3'(d);
            if (psum >= 3'd3) begin
               psum = psum - 3'd3;
            end
            slot_in.t_acc  = 12'(q);
            slot_in.tdig_o = {stage_in.tdig_o[11:0], d};
            slot_in.par_t  = psum[1:0];
         end
         if (flip_act) begin
            fb = stage_in.f_acc[10];
            slot_in.f_acc   = {stage_in.f_acc[9:0], 1'b0};
            slot_in.fbits_o = {fb, stage_in.fbits_o[10:1]};
            slot_in.par_f   = stage_in.par_f ^ fb;
         end
         if (p >= 4'd8) begin
            p_new = p - 4'd4;
         end
         if (stage_in.k != 3'd0 && stage_in.s_acc >= coef) begin
            slot_in.s_acc = stage_in.s_acc - coef;
            p_new         = 4'd7 + 4'(stage_in.k);
            slot_in.k     = stage_in.k - 3'd1;
         end
      end
      slot_in.pieces_o = {p_new, stage_in.pieces_o[47:4]};
   end

   // clear the whole record on reset so no stale item survives
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign stage_out = slot_ff;

endmodule

[design/cube_phase1_coordinate_codec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_phase1_coordinate_codec_core: phase-one cube coordinate codec
// Encodes corner twists, edge flips and slice slots into three search
// coordinates, or decodes the coordinates back into piece data.
// ----------------------------------------------------------------------------
// An item is taken on every clock edge with start high; busy never rises,
// so a new item may follow each cycle. Each item's result appears on the
// rsp_ ports with rsp_valid high for one cycle, after the item has passed
// twelve slot cells in a row (one per edge slot; cells 0..6 also handle a
// corner and cells 0..10 a flip) and then the output register. Results
// leave in item order and cannot be held off; the receiver must take each
// one in its cycle. In encode mode the decode outputs read zero, and the
// reverse in decode mode.
module cube_phase1_coordinate_codec_core
   import pcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_twist_digits,
   input  logic [11:0] req_flip_bits,
   input  logic [47:0] req_slot_pieces,
   input  logic [11:0] req_twist_coord,
   input  logic [10:0] req_flip_coord,
   input  logic [8:0]  req_slice_coord,
   output logic        rsp_valid,
   output logic [11:0] rsp_twist_coord_out,
   output logic [10:0] rsp_flip_coord_out,
   output logic [8:0]  rsp_slice_coord_out,
   output logic [15:0] rsp_twist_digits_out,
   output logic [11:0] rsp_flip_bits_out,
   output logic [47:0] rsp_slot_pieces_out,
   output logic        rsp_range_error
);

   stage_type  head;
   stage_type  chain [SLOTS+1];

   logic        rsp_valid_ff,      rsp_valid_in;
   logic [11:0] twist_coord_ff,    twist_coord_in;
   logic [10:0] flip_coord_ff,     flip_coord_in;
   logic [8:0]  slice_coord_ff,    slice_coord_in;
   logic [15:0] twist_digits_ff,   twist_digits_in;
   logic [11:0] flip_bits_ff,      flip_bits_in;
   logic [47:0] slot_pieces_ff,    slot_pieces_in;
   logic        range_error_ff,    range_error_in;
   logic [1:0]  last_twist;
   stage_type   tail;

   // the pipeline takes a new item every cycle
   assign busy = 1'b0;

   // load the item into the head of the chain; decode range checks start here
   always_comb begin
      head          = '0;
      head.valid    = start;
      head.cmd      = req_cmd;
      head.tdig     = req_twist_digits[13:0];
      head.fbits    = req_flip_bits[10:0];
      head.pieces   = req_slot_pieces;
      head.k        = 3'(SLICE_EDGES);
      if (req_cmd == CMD_DECODE) begin
         head.t_acc = req_twist_coord;
         head.f_acc = req_flip_coord;
         head.s_acc = req_slice_coord;
         head.err   = (req_twist_coord > 12'(TWIST_MAX)) ||
                      (req_slice_coord > 9'(SLICE_MAX));
      end
   end

   assign chain[0] = head;

   // one cell per slot; slot i also owns corner i for i < 7 and flip i for i < 11
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      pcc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (4'(g)),
         .stage_in   (chain[g]),
         .stage_out  (chain[g+1])
      );
   end

   assign tail = chain[SLOTS];

   // infer the eighth twist: bring the digit sum to a multiple of three
   always_comb begin
      case (tail.par_t)
         2'd1:    last_twist = 2'd2;
         2'd2:    last_twist = 2'd1;
         default: last_twist = 2'd0;
      endcase
   end

   // pick the mode's outputs and zero the others
   always_comb begin
      rsp_valid_in    = tail.valid;
      range_error_in  = tail.err;
      twist_coord_in  = '0;
      flip_coord_in   = '0;
      slice_coord_in  = '0;
      twist_digits_in = '0;
      flip_bits_in    = '0;
      slot_pieces_in  = '0;
      if (tail.cmd == CMD_ENCODE) begin
         twist_coord_in = tail.t_acc;
         flip_coord_in  = tail.f_acc;
         slice_coord_in = tail.s_acc;
      end else begin
         twist_digits_in = {last_twist, tail.tdig_o};
         // the twelfth flip equals the parity of the other eleven
         flip_bits_in    = {tail.par_f, tail.fbits_o};
         slot_pieces_in  = tail.pieces_o;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result payload for its one cycle on the ports
   always_ff @(posedge clock) begin
      twist_coord_ff  <= twist_coord_in;
      flip_coord_ff   <= flip_coord_in;
      slice_coord_ff  <= slice_coord_in;
      twist_digits_ff <= twist_digits_in;
      flip_bits_ff    <= flip_bits_in;
      slot_pieces_ff  <= slot_pieces_in;
      range_error_ff  <= range_error_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_twist_coord_out  = twist_coord_ff;
   assign rsp_flip_coord_out   = flip_coord_ff;
   assign rsp_slice_coord_out  = slice_coord_ff;
   assign rsp_twist_digits_out = twist_digits_ff;
   assign rsp_flip_bits_out    = flip_bits_ff;
   assign rsp_slot_pieces_out  = slot_pieces_ff;
   assign rsp_range_error      = range_error_ff;

endmodule

[design/pcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks of the phase-one coordinate codec
// Checks latency, ordering of strobes and mode exclusivity of the outputs.
// ----------------------------------------------------------------------------
module pcc_checker
   import pcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_cmd,
   input  logic [8:0]  req_slice_coord,
   input  logic        rsp_valid,
   input  logic [11:0] rsp_twist_coord_out,
   input  logic [10:0] rsp_flip_coord_out,
   input  logic [8:0]  rsp_slice_coord_out,
   input  logic [15:0] rsp_twist_digits_out,
   input  logic [11:0] rsp_flip_bits_out,
   input  logic [47:0] rsp_slot_pieces_out,
   input  logic        rsp_range_error
);

   // every item taken comes out as a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##13 rsp_valid)
      else $error("result missing thirteen cycles after item");

   // no result without a matching item taken before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 13))
      else $error("result without a matching item");

   // a decode slice range error comes out with the item that caused it
   a_decode_err: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_DECODE && req_slice_coord > 9'(SLICE_MAX))
      |-> ##13 rsp_range_error)
      else $error("slice range error lost");

   // while rsp_valid is high, one mode's outputs are all zero
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_twist_coord_out == '0 && rsp_flip_coord_out == '0 &&
                      rsp_slice_coord_out == '0) ||
                     (rsp_twist_digits_out == '0 && rsp_flip_bits_out == '0 &&
                      rsp_slot_pieces_out == '0)))
      else $error("both encode and decode outputs nonzero");

endmodule

bind cube_phase1_coordinate_codec_core pcc_checker u_pcc_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the phase-one coordinate codec core
// Drives encode and decode items through the start/busy command port,
// predicts each result with a local model of the conversions (or takes a
// hand-written one) and checks each rsp_valid strobe field by field, in item order.
// ----------------------------------------------------------------------------
module tb;
   import pcc_pkg::*;

   localparam int RANDOM_ITEMS = 830;
   localparam int DRAIN_CYCLES = 30;   // idle cycles after the drain, to catch stray results
   localparam int DUE_DEPTH    = 1024; // ring of expected results

   // one input item and one result, at the port widths
   typedef struct packed {
      logic        cmd;
      logic [15:0] twist_digits;
      logic [11:0] flip_bits;
      logic [47:0] slot_pieces;
      logic [11:0] twist_coord;
      logic [10:0] flip_coord;
      logic [8:0]  slice_coord;
   } codec_req_t;

   typedef struct packed {
      logic [11:0] twist_coord;
      logic [10:0] flip_coord;
      logic [8:0]  slice_coord;
      logic [15:0] twist_digits;
      logic [11:0] flip_bits;
      logic [47:0] slot_pieces;
      logic        range_error;
   } codec_rsp_t;

   // directed row: the item, plus a hand-written result where one is obvious
   typedef struct packed {
      codec_req_t req;
      logic       known;
      codec_rsp_t rsp;
   } codec_row_t;

   localparam int DIRECTED_ROWS = 18;

   codec_row_t directed_rows [DIRECTED_ROWS] = '{
      // all-zero encode: every coordinate zero
      '{'{CMD_ENCODE, 16'h0000, 12'h000, 48'h0000_0000_0000, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}},
      // all-zero decode: rank 0 puts the slice edges in slots 8..11
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'h0000_0000_0000, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h89AB_0000_0000, 1'b0}},
      // all-ones encode: twist digit of 3 everywhere, pieces above 11
      '{'{CMD_ENCODE, 16'hFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF, 12'hFFF, 11'h7FF, 9'h1FF},
        1'b1, '{12'd3279, 11'd2047, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b1}},
      // all-ones decode: both coordinates out of range
      '{'{CMD_DECODE, 16'hFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF, 12'hFFF, 11'h7FF, 9'h1FF},
        1'b0, '0},
      // solved cube encodes to zero
      '{'{CMD_ENCODE, 16'h0000, 12'h000, 48'hBA98_7654_3210, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}},
      // largest legal coordinates: slice edges in slots 0..3
      '{'{CMD_ENCODE, 16'h2AAA, 12'h7FF, 48'h7654_3210_BA98, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd2186, 11'd2047, 9'd494, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}},
      // and back again
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'h0000_0000_0000, 12'd2186, 11'd2047, 9'd494},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h6AAA, 12'hFFF, 48'h0000_0000_89AB, 1'b0}},
      // twist coordinate one past its range
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'hBA98_7654_3210, 12'd2187, 11'd5, 9'd17},
        1'b0, '0},
      // slice coordinate one past its range
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'hBA98_7654_3210, 12'd42, 11'd1024, 9'd495},
        1'b0, '0},
      // twist of 3 on corner 7 is never read
      '{'{CMD_ENCODE, 16'hC000, 12'h000, 48'h0000_0000_0000, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}},
      // one piece of 12 flags an error
      '{'{CMD_ENCODE, 16'h0000, 12'h000, 48'h0000_00C0_0000, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b1}},
      // only two slice edges present
      '{'{CMD_ENCODE, 16'h1234, 12'h0A5, 48'h8000_0000_0009, 12'd0, 11'd0, 9'd0},
        1'b0, '0},
      // twelve slice edges: only the first four count
      '{'{CMD_ENCODE, 16'h0000, 12'h000, 48'h8888_8888_8888, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd494, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}},
      // decode rewrites a solved piece layout
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'hBA98_7654_3210, 12'd1, 11'd1, 9'd100},
        1'b0, '0},
      // pieces of 8 or more drop by four, except in slots that get a slice edge
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'hFFFF_FFFF_FFFF, 12'd0, 11'd0, 9'd0},
        1'b0, '0},
      '{'{CMD_ENCODE, 16'h5555, 12'h555, 48'h0123_4567_89AB, 12'd0, 11'd0, 9'd0},
        1'b0, '0},
      '{'{CMD_DECODE, 16'h0000, 12'h000, 48'h3210_BA98_7654, 12'd4095, 11'd0, 9'd330},
        1'b0, '0},
      // flip of edge 11 is never read
      '{'{CMD_ENCODE, 16'h0000, 12'h800, 48'h0000_0000_0000, 12'd0, 11'd0, 9'd0},
        1'b1, '{12'd0, 11'd0, 9'd0, 16'h0000, 12'h000, 48'h0000_0000_0000, 1'b0}}
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [15:0] req_twist_digits;
   logic [11:0] req_flip_bits;
   logic [47:0] req_slot_pieces;
   logic [11:0] req_twist_coord;
   logic [10:0] req_flip_coord;
   logic [8:0]  req_slice_coord;
   logic        rsp_valid;
   logic [11:0] rsp_twist_coord_out;
   logic [10:0] rsp_flip_coord_out;
   logic [8:0]  rsp_slice_coord_out;
   logic [15:0] rsp_twist_digits_out;
   logic [11:0] rsp_flip_bits_out;
   logic [47:0] rsp_slot_pieces_out;
   logic        rsp_range_error;

   // a hand-written result travels with its item and is used on acceptance
   logic        row_known;
   codec_rsp_t  row_known_rsp;

   // expected results in item order; due_wr and due_rd count in and out
   codec_rsp_t  results_due [DUE_DEPTH];
   int          due_wr = 0;
   int          due_rd = 0;
   int          mismatch_count;
   int          burst_left;

   cube_phase1_coordinate_codec_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_twist_digits     (req_twist_digits),
      .req_flip_bits        (req_flip_bits),
      .req_slot_pieces      (req_slot_pieces),
      .req_twist_coord      (req_twist_coord),
      .req_flip_coord       (req_flip_coord),
      .req_slice_coord      (req_slice_coord),
      .rsp_valid            (rsp_valid),
      .rsp_twist_coord_out  (rsp_twist_coord_out),
      .rsp_flip_coord_out   (rsp_flip_coord_out),
      .rsp_slice_coord_out  (rsp_slice_coord_out),
      .rsp_twist_digits_out (rsp_twist_digits_out),
      .rsp_flip_bits_out    (rsp_flip_bits_out),
      .rsp_slot_pieces_out  (rsp_slot_pieces_out),
      .rsp_range_error      (rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case results never arrive
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // C(n, k); each partial product is itself a binomial, so the division
   // is exact, and n < k reaches a zero factor and stays zero
   function automatic int choose(int n, int k);
      int r;
      r = 1;
      for (int j = 0; j < k; j++)
         r = r * (n - j) / (j + 1);
      return r;
   endfunction

   // what the codec returns for one item
   function automatic codec_rsp_t predict_conversion(codec_req_t r);
      codec_rsp_t o;
      int         left;     // slice edges still to place
      int         rank;     // slice sum, or rank still to unrank
      int         quot;
      int         par;
      logic [3:0] piece;
      logic [1:0] digit;
      o = '0;
      left = 4;
      par = 0;
      if (r.cmd == CMD_ENCODE) begin
         quot = 0;
         for (int i = 0; i < 7; i++) begin
            digit = r.twist_digits[2*i +: 2];
            if (digit == 2'd3)
               o.range_error = 1'b1;
            quot = quot * 3 + digit;
         end
         o.twist_coord = quot[11:0];
         for (int i = 0; i < 11; i++)
            o.flip_coord = {o.flip_coord[9:0], r.flip_bits[i]};
         rank = 0;
         for (int i = 0; i < 12; i++) begin
            piece = r.slot_pieces[4*i +: 4];
            if (piece > 4'd11)
               o.range_error = 1'b1;
            if (piece >= 4'd8 && piece <= 4'd11 && left > 0) begin
               rank += choose(11 - i, left);
               left--;
            end
         end
         o.slice_coord = rank[8:0];
      end else begin
         if (r.twist_coord > 12'd2186 || r.slice_coord > 9'd494)
            o.range_error = 1'b1;
         // lowest base-3 digit belongs to corner 6
         quot = r.twist_coord;
         for (int i = 6; i >= 0; i--) begin
            o.twist_digits[2*i +: 2] = 2'(quot % 3);
            par += quot % 3;
            quot = quot / 3;
         end
         o.twist_digits[15:14] = 2'((3 - par % 3) % 3);
         par = 0;
         for (int i = 0; i < 11; i++) begin
            o.flip_bits[i] = r.flip_coord[10 - i];
            par += r.flip_coord[10 - i];
         end
         o.flip_bits[11] = par[0];
         rank = r.slice_coord;
         for (int i = 0; i < 12; i++) begin
            piece = r.slot_pieces[4*i +: 4];
            if (piece >= 4'd8)
               piece = piece - 4'd4;
            if (left > 0 && rank >= choose(11 - i, left)) begin
               rank -= choose(11 - i, left);
               piece = 4'(7 + left);
               left--;
            end
            o.slot_pieces[4*i +: 4] = piece;
         end
      end
      return o;
   endfunction

   // a real edge arrangement: pieces 0..11 in a random order
   function automatic logic [47:0] shuffled_edges();
      int          slot [12];
      int          pick;
      int          hold;
      logic [47:0] packed_slots;
      for (int i = 0; i < 12; i++)
         slot[i] = i;
      for (int i = 11; i > 0; i--) begin
         pick = $urandom_range(0, i);
         hold = slot[i];
         slot[i] = slot[pick];
         slot[pick] = hold;
      end
      for (int i = 0; i < 12; i++)
         packed_slots[4*i +: 4] = 4'(slot[i]);
      return packed_slots;
   endfunction

   // mostly well-formed cube data with random content, some raw noise
   function automatic codec_req_t random_request();
      codec_req_t r;
      int         kind;
      kind = $urandom_range(0, 9);
      r.cmd              = 1'($urandom);
      r.twist_digits     = 16'($urandom);
      r.flip_bits        = 12'($urandom);
      r.slot_pieces      = {16'($urandom), 32'($urandom)};
      r.twist_coord      = 12'($urandom);
      r.flip_coord       = 11'($urandom);
      r.slice_coord      = 9'($urandom);
      if (kind <= 3) begin
         r.cmd = CMD_ENCODE;
         for (int i = 0; i < 7; i++)
            r.twist_digits[2*i +: 2] = 2'($urandom_range(0, 2));
         r.slot_pieces = shuffled_edges();
      end else if (kind <= 6) begin
         r.cmd         = CMD_DECODE;
         r.twist_coord = 12'($urandom_range(0, 2186));
         r.slice_coord = 9'($urandom_range(0, 494));
         if (kind != 6)
            r.slot_pieces = shuffled_edges();
      end
      return r;
   endfunction

   task automatic report_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_result(codec_rsp_t want, codec_rsp_t got);
      report_field("twist_coord_out", 48'(want.twist_coord), 48'(got.twist_coord));
      report_field("flip_coord_out", 48'(want.flip_coord), 48'(got.flip_coord));
      report_field("slice_coord_out", 48'(want.slice_coord), 48'(got.slice_coord));
      report_field("twist_digits_out", 48'(want.twist_digits), 48'(got.twist_digits));
      report_field("flip_bits_out", 48'(want.flip_bits), 48'(got.flip_bits));
      report_field("slot_pieces_out", want.slot_pieces, got.slot_pieces);
      report_field("range_error", 48'(want.range_error), 48'(got.range_error));
   endtask

   // Present one item and hold it until the block takes it. Items go out in
   // bursts of random length; between bursts drop start for a random gap,
   // or for none at all so that long back-to-back stretches occur too.
   // Called right after a rising edge; start only falls when a gap follows.
   task automatic issue_item(codec_req_t r, logic known, codec_rsp_t known_rsp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_cmd          <= r.cmd;
      req_twist_digits <= r.twist_digits;
      req_flip_bits    <= r.flip_bits;
      req_slot_pieces  <= r.slot_pieces;
      req_twist_coord  <= r.twist_coord;
      req_flip_coord   <= r.flip_coord;
      req_slice_coord  <= r.slice_coord;
      row_known        <= known;
      row_known_rsp    <= known_rsp;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Scoreboard. Everything is sampled at the rising edge, so values are the
   // ones that held through the cycle that edge ends. Record the expected
   // result of an accepted item first, then match any result strobe against
   // the oldest expectation.
   always @(posedge clock) begin : scoreboard
      codec_req_t taken;
      codec_rsp_t got;
      if (!reset) begin
         if (start && !busy) begin
            taken = {req_cmd, req_twist_digits, req_flip_bits, req_slot_pieces,
                     req_twist_coord, req_flip_coord, req_slice_coord};
            results_due[due_wr % DUE_DEPTH] = row_known ? row_known_rsp
                                                        : predict_conversion(taken);
            due_wr++;
         end
         if (rsp_valid) begin
            got = {rsp_twist_coord_out, rsp_flip_coord_out, rsp_slice_coord_out,
                   rsp_twist_digits_out, rsp_flip_bits_out, rsp_slot_pieces_out,
                   rsp_range_error};
            if (due_wr == due_rd) begin
               $display("%0t: result with nothing expected, actual %h", $time, got);
               mismatch_count++;
            end else begin
               compare_result(results_due[due_rd % DUE_DEPTH], got);
               due_rd++;
            end
         end
      end
   end

   initial begin
      mismatch_count   = 0;
      burst_left       = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_cmd          <= CMD_ENCODE;
      req_twist_digits <= '0;
      req_flip_bits    <= '0;
      req_slot_pieces  <= '0;
      req_twist_coord  <= '0;
      req_flip_coord   <= '0;
      req_slice_coord  <= '0;
      row_known        <= 1'b0;
      row_known_rsp    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed items: extremes, both commands, each corner case
      foreach (directed_rows[i])
         issue_item(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp);

      // random items; halfway through, hold off until the pipe runs dry
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (due_wr != due_rd);
         end
         issue_item(random_request(), 1'b0, '0);
      end
      start <= 1'b0;

      // drain, then linger to catch any stray result
      while (due_wr != due_rd)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
